@@ src/nqbs_pkg.sv @@
`default_nettype none
package nqbs_pkg;

  // Width of the board size field on the input port
  localparam int unsigned SizeW = 5;

  // Command from the search sequencer to the occupancy masks
  typedef struct packed {
    logic clr;    // wipe all masks for a fresh search
    logic place;  // mark the square's column and diagonals as taken
    logic lift;   // free the square's column and diagonals again
  } nqbs_occ_cmd_t;

endpackage
`default_nettype wire

@@ src/n_queens_backtrack_search_unit.sv @@
`default_nettype none
// Channel  | Ports                               | Word
// ---------+-------------------------------------+------------------------------
// input    | in_valid, in_ready, in_board_size   | board size 0..31, saturated
// result   | out_valid, out_ready, out_solvable  | 1 if a placement exists
//
// One column probe per scan cycle; each step back takes the scan step that runs
// off the row, then the stack read in the pop state that lifts the queen.
// A word passes through accept, the column probes, a final check and finish;
// the stack read is registered, so each step back also passes through the pop state.
// Reset clears control and masks at once; no clearing pass for the stack.
// A word is taken while an earlier result still waits; a stalled result
// holds the search at its last step until the output register frees.
module n_queens_backtrack_search_unit
  import nqbs_pkg::*;
#(
  parameter int unsigned MAX_BOARD = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [SizeW-1:0] in_board_size,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_solvable
);

  localparam int unsigned CW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
  localparam int unsigned RW = $clog2(MAX_BOARD + 1);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StPop    = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [RW-1:0] n_r, n_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] col_r, col_nxt;
  logic          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_solvable_r, out_solvable_nxt;

  logic [RW-1:0] n_sat;
  logic [RW-1:0] row_dec;
  logic          free;
  logic [CW-1:0] occ_col;
  logic [CW-1:0] q_col;
  nqbs_occ_cmd_t occ_cmd;
  logic          mem_wr_en, mem_rd_en;

  // Saturate the requested size to the board limit
  assign n_sat = ({1'b0, in_board_size} > (SizeW + 1)'(MAX_BOARD)) ?
                 RW'(MAX_BOARD) : RW'(in_board_size);

  assign row_dec  = row_r - RW'(1);
  assign in_ready = (state_r == StIdle);
  assign occ_col  = (state_r == StPop) ? q_col : col_r[CW-1:0];

  // Stack of placed columns
  nqbs_stack_mem #(
    .DEPTH (MAX_BOARD),
    .AW    (CW),
    .DW    (CW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (row_r[CW-1:0]),
    .wr_data (col_r[CW-1:0]),
    .rd_en   (mem_rd_en),
    .rd_addr (row_dec[CW-1:0]),
    .rd_data (q_col)
  );

  // Column and diagonal masks
  nqbs_occupancy #(
    .MAX_BOARD (MAX_BOARD),
    .CW        (CW)
  ) u_occ (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (occ_cmd),
    .row   (row_r[CW-1:0]),
    .col   (occ_col),
    .free  (free)
  );

  // Search sequencer
  always_comb begin
    state_nxt        = state_r;
    n_nxt            = n_r;
    row_nxt          = row_r;
    col_nxt          = col_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_solvable_nxt = out_solvable_r;
    occ_cmd          = '0;
    mem_wr_en        = 1'b0;
    mem_rd_en        = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          n_nxt       = n_sat;
          row_nxt     = '0;
          col_nxt     = '0;
          occ_cmd.clr = 1'b1;
          state_nxt   = StScan;
        end
      end
      StScan: begin
        priority if (row_r == n_r) begin
          res_nxt   = 1'b1;
          state_nxt = StFinish;
        end else if (col_r == n_r) begin
          if (row_r == '0) begin
            res_nxt   = 1'b0;
            state_nxt = StFinish;
          end else begin
            mem_rd_en = 1'b1;
            row_nxt   = row_dec;
            state_nxt = StPop;
          end
        end else if (free) begin
          mem_wr_en     = 1'b1;
          occ_cmd.place = 1'b1;
          row_nxt       = row_r + RW'(1);
          col_nxt       = '0;
        end else begin
          col_nxt = col_r + RW'(1);
        end
      end
      StPop: begin
        occ_cmd.lift = 1'b1;
        col_nxt      = RW'(q_col) + RW'(1);
        state_nxt    = StScan;
      end
      StFinish: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_solvable_nxt = res_r;
          state_nxt        = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      n_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      res_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    out_solvable_r <= out_solvable_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_solvable = out_solvable_r;

  // A stack read always comes from a step back in the scan
  a_pop_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StPop) |-> ($past(state_r) == StScan))
    else $error("pop state entered without a scan step back");

  // The search never runs past the board
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StScan) |-> (row_r <= n_r && col_r <= n_r))
    else $error("search row or column beyond board size");

  // A pending result blocks the finish step
  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StFinish && out_valid_r && !out_ready) |=> (state_r == StFinish))
    else $error("finish overwrote a pending result");

  // A new result word only follows a finish step
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> ($past(state_r) == StFinish))
    else $error("result raised outside finish");

endmodule
`default_nettype wire

@@ src/nqbs_stack_mem.sv @@
`default_nettype none
module nqbs_stack_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  // One stored column per placed row
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write the placed column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the output holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ src/nqbs_occupancy.sv @@
`default_nettype none
module nqbs_occupancy
  import nqbs_pkg::*;
#(
  parameter int unsigned MAX_BOARD = 16,
  parameter int unsigned CW        = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire nqbs_occ_cmd_t cmd,
  input  wire logic [CW-1:0] row,
  input  wire logic [CW-1:0] col,
  output logic               free
);

  localparam int unsigned DN = 2 * MAX_BOARD - 1;
  localparam int unsigned DW = $clog2(2 * MAX_BOARD);

  logic [MAX_BOARD-1:0] col_m_r, col_m_nxt;
  logic [DN-1:0]        up_m_r, up_m_nxt;
  logic [DN-1:0]        dn_m_r, dn_m_nxt;
  logic [DW-1:0]        up_idx, dn_idx;

  // Index the two diagonals through the square
  assign up_idx = DW'(row) + DW'(col);
  assign dn_idx = DW'(row) + DW'(MAX_BOARD - 1) - DW'(col);

  assign free = !col_m_r[col] && !up_m_r[up_idx] && !dn_m_r[dn_idx];

  // Clear all masks, or set or clear the masks for the addressed square
  always_comb begin
    col_m_nxt = col_m_r;
    up_m_nxt  = up_m_r;
    dn_m_nxt  = dn_m_r;
    priority if (cmd.clr) begin
      col_m_nxt = '0;
      up_m_nxt  = '0;
      dn_m_nxt  = '0;
    end else if (cmd.place) begin
      col_m_nxt[col]   = 1'b1;
      up_m_nxt[up_idx] = 1'b1;
      dn_m_nxt[dn_idx] = 1'b1;
    end else if (cmd.lift) begin
      col_m_nxt[col]   = 1'b0;
      up_m_nxt[up_idx] = 1'b0;
      dn_m_nxt[dn_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_m_r <= '0;
      up_m_r  <= '0;
      dn_m_r  <= '0;
    end else begin
      col_m_r <= col_m_nxt;
      up_m_r  <= up_m_nxt;
      dn_m_r  <= dn_m_nxt;
    end
  end

endmodule
`default_nettype wire
